// ===== design/uwbt_pkg.sv =====
// Shared constants, types and character classes for the word boundary tokenizer.
`default_nettype none

package uwbt_pkg;

  localparam int unsigned CpW        = 21;
  localparam int unsigned LengthBits = 16;
  localparam int unsigned CfgIdxW    = 1;

  localparam logic [LengthBits-1:0] LenMax = '1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgSentenceEn  = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgParagraphEn = 1'd1;

  // input opcodes
  localparam logic OpText = 1'b0;
  localparam logic OpEnd  = 1'b1;

  // result kinds
  localparam logic KindCodepoint = 1'b0;
  localparam logic KindRecord    = 1'b1;

  // code points that take part in paragraph breaks
  localparam logic [CpW-1:0] CpLineFeed  = 21'h00000A;
  localparam logic [CpW-1:0] CpFormFeed  = 21'h00000C;
  localparam logic [CpW-1:0] CpParaSep   = 21'h002029;

  // result queue geometry
  localparam int unsigned RqDepth = 4;
  localparam int unsigned RqPtrW  = $clog2(RqDepth);
  localparam int unsigned RqCntW  = $clog2(RqDepth + 1);

  typedef struct packed {
    logic                  kind;
    logic [CpW-1:0]        word_codepoint;
    logic                  first_of_word;
    logic [LengthBits-1:0] word_length;
    logic                  sentence_end;
    logic                  paragraph_end;
    logic                  end_of_document;
    logic                  last_in_run;
  } result_t;

  // up to two results written into the queue in one cycle
  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

  function automatic logic is_space(input logic [CpW-1:0] c);
    logic hit;
    hit = 1'b0;
    if (c >= 21'h000009 && c <= 21'h00000D) hit = 1'b1;
    if (c == 21'h000020 || c == 21'h0000A0 || c == 21'h001680) hit = 1'b1;
    if (c >= 21'h002000 && c <= 21'h00200A) hit = 1'b1;
    if (c == 21'h002028 || c == 21'h002029 || c == 21'h00202F ||
        c == 21'h00205F || c == 21'h003000) hit = 1'b1;
    return hit;
  endfunction

  function automatic logic is_ender(input logic [CpW-1:0] c);
    logic hit;
    hit = 1'b0;
    case (c)
      21'h00002E, 21'h000021, 21'h00003F,
      21'h003002, 21'h00FF01, 21'h00FF1F, 21'h00FF0E,
      21'h0006D4, 21'h00061F,
      21'h000964, 21'h000965,
      21'h000589, 21'h00055C, 21'h00055E,
      21'h00037E,
      21'h001362, 21'h001367, 21'h001368,
      21'h00104A, 21'h00104B,
      21'h000F0D, 21'h000F0E,
      21'h0010FB,
      21'h0017D4, 21'h0017D5: hit = 1'b1;
      default:                hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

`default_nettype wire

// ===== design/uwbt_if.sv =====
// Handshake channels: text input, result output and configuration writes.
`default_nettype none

interface uwbt_in_if;
  logic                     valid;
  logic                     ready;
  logic                     opcode;
  logic [uwbt_pkg::CpW-1:0] codepoint;
  modport source (output valid, opcode, codepoint, input ready);
  modport sink   (input valid, opcode, codepoint, output ready);
endinterface

interface uwbt_out_if;
  logic                            valid;
  logic                            ready;
  logic                            kind;
  logic [uwbt_pkg::CpW-1:0]        word_codepoint;
  logic                            first_of_word;
  logic [uwbt_pkg::LengthBits-1:0] word_length;
  logic                            sentence_end;
  logic                            paragraph_end;
  logic                            end_of_document;
  logic                            last_in_run;
  modport source (output valid, kind, word_codepoint, first_of_word, word_length,
                  sentence_end, paragraph_end, end_of_document, last_in_run,
                  input ready);
  modport sink   (input valid, kind, word_codepoint, first_of_word, word_length,
                  sentence_end, paragraph_end, end_of_document, last_in_run,
                  output ready);
endinterface

interface uwbt_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [uwbt_pkg::CfgIdxW-1:0] index;
  logic                         data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== design/uwbt_rq.sv =====
// Small result queue: takes up to two results a cycle, hands out one.
`default_nettype none

module uwbt_rq (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire uwbt_pkg::push_t push_i,
  output logic                 room_o,
  uwbt_out_if.source           out_o
);

  uwbt_pkg::result_t                 mem_q [uwbt_pkg::RqDepth];
  logic [uwbt_pkg::RqPtrW-1:0]       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [uwbt_pkg::RqCntW-1:0]       count_q, count_d;
  logic                              pop;
  logic [uwbt_pkg::RqPtrW-1:0]       wr_ptr_nx;
  uwbt_pkg::result_t                 head;

  assign head      = mem_q[rd_ptr_q];
  assign pop       = out_o.valid && out_o.ready;
  assign wr_ptr_nx = wr_ptr_q + uwbt_pkg::RqPtrW'(1);

  // two free slots are needed before the next item may be processed
  assign room_o = (count_q <= uwbt_pkg::RqCntW'(uwbt_pkg::RqDepth - 2));

  always_comb begin
    wr_ptr_d = wr_ptr_q + uwbt_pkg::RqPtrW'(push_i.n);
    rd_ptr_d = rd_ptr_q + uwbt_pkg::RqPtrW'(pop);
    count_d  = count_q + uwbt_pkg::RqCntW'(push_i.n) - uwbt_pkg::RqCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.n == 2'd2) begin
      mem_q[wr_ptr_nx] <= push_i.r1;
    end
  end

  assign out_o.valid           = (count_q != '0);
  assign out_o.kind            = head.kind;
  assign out_o.word_codepoint  = head.word_codepoint;
  assign out_o.first_of_word   = head.first_of_word;
  assign out_o.word_length     = head.word_length;
  assign out_o.sentence_end    = head.sentence_end;
  assign out_o.paragraph_end   = head.paragraph_end;
  assign out_o.end_of_document = head.end_of_document;
  assign out_o.last_in_run     = head.last_in_run;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= uwbt_pkg::RqCntW'(uwbt_pkg::RqDepth))
    else $error("result queue overflow");

endmodule

`default_nettype wire

// ===== design/unicode_word_boundary_tokenizer_unit.sv =====
// Top level of the streaming whitespace word tokenizer.
`default_nettype none

// Streaming word tokenizer. One code point (or an end-of-text item) is taken
// per cycle on in_i. Each item is classified on the way into an input
// register (whitespace, sentence ender, line feed, form feed, paragraph
// separator); once the queue has room, one pass of compare logic updates the word
// state and writes zero, one or two results into a four-entry result queue
// that drives out_o. Non-whitespace code points come out as word code points,
// the first of each word flagged. A word's closing record (length,
// sentence end, paragraph end) is held back through the following whitespace
// and sent just before the next word's first code point, or on end of text,
// which always closes a paragraph and returns the stream state to reset.
// Rate: one item per cycle while results are taken at one per cycle. An
// item that starts a word after a closed one yields two results, but the
// whitespace that closed that word yielded none, so results never outrun
// items. The input stalls only while the queue has fewer than two free
// slots, i.e. when the receiver holds off. An item's results pass through
// the input register and then the result queue before they are taken. Configuration
// writes are taken in any cycle (cfg_i.ready is held high) and should only be
// issued while the block is idle.
module unicode_word_boundary_tokenizer_unit (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  uwbt_in_if.sink    in_i,
  uwbt_out_if.source out_o,
  uwbt_cfg_if.sink   cfg_i
);

  // ---- configuration registers ----
  logic sent_en_q, para_en_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sent_en_q <= 1'b1;
      para_en_q <= 1'b1;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        uwbt_pkg::CfgSentenceEn:  sent_en_q <= cfg_i.data;
        uwbt_pkg::CfgParagraphEn: para_en_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // ---- input register with precomputed character classes ----
  logic                     s_valid_q;
  logic                     s_op_q;
  logic [uwbt_pkg::CpW-1:0] s_cp_q;
  logic                     s_ws_q, s_ender_q, s_lf_q, s_ff_q, s_ps_q;
  logic                     room;
  logic                     advance;

  assign advance    = s_valid_q && room;
  assign in_i.ready = !s_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s_op_q    <= in_i.opcode;
      s_cp_q    <= in_i.codepoint;
      s_ws_q    <= uwbt_pkg::is_space(in_i.codepoint);
      s_ender_q <= uwbt_pkg::is_ender(in_i.codepoint);
      s_lf_q    <= (in_i.codepoint == uwbt_pkg::CpLineFeed);
      s_ff_q    <= (in_i.codepoint == uwbt_pkg::CpFormFeed);
      s_ps_q    <= (in_i.codepoint == uwbt_pkg::CpParaSep);
    end
  end

  // ---- stream state ----
  // The previous code point only matters through three classes, so those
  // are kept instead of the code point itself.
  logic                            prev_lf_q, prev_ff_q, prev_ps_q;
  logic                            prev_lf_d, prev_ff_d, prev_ps_d;
  logic                            word_open_q, word_open_d;
  logic [uwbt_pkg::LengthBits-1:0] open_len_q, open_len_d;
  logic                            open_ender_q, open_ender_d;
  logic                            held_valid_q, held_valid_d;
  logic [uwbt_pkg::LengthBits-1:0] held_len_q, held_len_d;
  logic                            held_es_q, held_es_d;
  logic                            held_ep_q, held_ep_d;

  uwbt_pkg::push_t   push;
  uwbt_pkg::result_t rec, cp_res;
  logic              para_brk;

  assign para_brk = (prev_lf_q && s_lf_q) || prev_ps_q || s_ps_q || prev_ff_q || s_ff_q;

  always_comb begin
    prev_lf_d    = prev_lf_q;
    prev_ff_d    = prev_ff_q;
    prev_ps_d    = prev_ps_q;
    word_open_d  = word_open_q;
    open_len_d   = open_len_q;
    open_ender_d = open_ender_q;
    held_valid_d = held_valid_q;
    held_len_d   = held_len_q;
    held_es_d    = held_es_q;
    held_ep_d    = held_ep_q;

    // closing record, from the open word or from the held one
    rec                 = '0;
    rec.kind            = uwbt_pkg::KindRecord;
    rec.word_length     = word_open_q ? open_len_q : held_len_q;
    rec.sentence_end    = word_open_q ? (open_ender_q && sent_en_q) : held_es_q;
    rec.paragraph_end   = word_open_q ? 1'b1 : held_ep_q;
    rec.end_of_document = (s_op_q == uwbt_pkg::OpEnd);

    cp_res                = '0;
    cp_res.kind           = uwbt_pkg::KindCodepoint;
    cp_res.word_codepoint = s_cp_q;
    cp_res.first_of_word  = !word_open_q;
    cp_res.last_in_run    = 1'b1;

    push    = '0;
    push.r0 = rec;
    push.r1 = cp_res;

    if (advance) begin
      if (s_op_q == uwbt_pkg::OpEnd) begin
        if (word_open_q || held_valid_q) begin
          // end of text closes a paragraph, held word or not
          push.n                = 2'd1;
          push.r0.paragraph_end = 1'b1;
          push.r0.last_in_run   = 1'b1;
        end
        prev_lf_d    = 1'b0;
        prev_ff_d    = 1'b0;
        prev_ps_d    = 1'b0;
        word_open_d  = 1'b0;
        open_len_d   = '0;
        open_ender_d = 1'b0;
        held_valid_d = 1'b0;
        held_len_d   = '0;
        held_es_d    = 1'b0;
        held_ep_d    = 1'b0;
      end else if (s_ws_q) begin
        if (word_open_q) begin
          held_valid_d = 1'b1;
          held_len_d   = open_len_q;
          held_es_d    = open_ender_q && sent_en_q;
          held_ep_d    = 1'b0;
          word_open_d  = 1'b0;
          open_len_d   = '0;
          open_ender_d = 1'b0;
        end
        if (held_valid_d && para_en_q && para_brk) begin
          held_ep_d = 1'b1;
        end
        prev_lf_d = s_lf_q;
        prev_ff_d = s_ff_q;
        prev_ps_d = s_ps_q;
      end else begin
        if (!word_open_q) begin
          if (held_valid_q) begin
            // held record goes out ahead of the new word's first code point
            push.n = 2'd2;
          end else begin
            push.n  = 2'd1;
            push.r0 = cp_res;
          end
          held_valid_d = 1'b0;
          held_len_d   = '0;
          held_es_d    = 1'b0;
          held_ep_d    = 1'b0;
          word_open_d  = 1'b1;
          open_len_d   = uwbt_pkg::LengthBits'(1);
        end else begin
          push.n  = 2'd1;
          push.r0 = cp_res;
          if (open_len_q != uwbt_pkg::LenMax) begin
            open_len_d = open_len_q + uwbt_pkg::LengthBits'(1);
          end
        end
        open_ender_d = s_ender_q;
        prev_lf_d    = s_lf_q;
        prev_ff_d    = s_ff_q;
        prev_ps_d    = s_ps_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_lf_q    <= 1'b0;
      prev_ff_q    <= 1'b0;
      prev_ps_q    <= 1'b0;
      word_open_q  <= 1'b0;
      open_len_q   <= '0;
      open_ender_q <= 1'b0;
      held_valid_q <= 1'b0;
      held_len_q   <= '0;
      held_es_q    <= 1'b0;
      held_ep_q    <= 1'b0;
    end else begin
      prev_lf_q    <= prev_lf_d;
      prev_ff_q    <= prev_ff_d;
      prev_ps_q    <= prev_ps_d;
      word_open_q  <= word_open_d;
      open_len_q   <= open_len_d;
      open_ender_q <= open_ender_d;
      held_valid_q <= held_valid_d;
      held_len_q   <= held_len_d;
      held_es_q    <= held_es_d;
      held_ep_q    <= held_ep_d;
    end
  end

  // ---- result queue ----
  uwbt_rq u_rq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .out_o  (out_o)
  );

  // ---- assertions ----
  a_open_xor_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(word_open_q && held_valid_q))
    else $error("open and held word at the same time");

  a_len_tracks_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    word_open_q == (open_len_q != '0))
    else $error("open word length out of step with word state");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && s_op_q == uwbt_pkg::OpEnd) |=>
      (!word_open_q && !held_valid_q && !prev_lf_q && !prev_ff_q && !prev_ps_q))
    else $error("end of text did not clear stream state");

  a_para_needs_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_ep_q |-> held_valid_q)
    else $error("paragraph mark without a held word");

endmodule

`default_nettype wire
